// ----- hw/rtl/tepq_pkg.sv -----
// ----------------------------------------------------------------------------
// tepq_pkg: shared types for the timed event priority queue
// Command and response words, cell entry layout and the cell operation codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tepq_pkg;

	localparam int TIME_W = 32;
	localparam int CHAN_W = 8;

	// command codes
	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_PEEK    = 2'd2,
		ACT_REPLACE = 2'd3
	} action_t;

	// response status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_EMPTY    = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_NOTFOUND = 2'd3
	} status_t;

	// operation broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_SHIFT  = 2'd2,
		CELL_REMOVE = 2'd3
	} cell_op_t;

	typedef struct packed {
		action_t             action;
		logic [TIME_W-1:0]   event_time;
		logic [CHAN_W-1:0]   channel;
	} cmd_t;

	typedef struct packed {
		status_t             status;
		logic [TIME_W-1:0]   out_time;
		logic [CHAN_W-1:0]   out_channel;
	} rsp_t;

	// one stored event
	typedef struct packed {
		logic                vld;
		logic [TIME_W-1:0]   tim;
		logic [CHAN_W-1:0]   chn;
	} entry_t;

	// control group driven by the sequencer into the chain
	typedef struct packed {
		cell_op_t            op;
		logic [TIME_W-1:0]   key_time;
		logic [CHAN_W-1:0]   key_chan;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tepq_cell.sv -----
// ----------------------------------------------------------------------------
// tepq_cell: one slot of the sorted event chain
// Holds one event, compares it with the broadcast key and moves data to or
// from its neighbors: insert shifts right, pop and remove shift left.
// ----------------------------------------------------------------------------
`default_nettype none

module tepq_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tepq_pkg::cell_ctl_t ctl,
	input  wire tepq_pkg::entry_t    left_ent,
	input  wire logic                left_gt,
	input  wire tepq_pkg::entry_t    right_ent,
	input  wire logic                seen_in,
	output tepq_pkg::entry_t         ent,
	output logic                     gt,
	output logic                     seen_out
);

	logic                         vld_q;
	logic [tepq_pkg::TIME_W-1:0]  tim_q;
	logic [tepq_pkg::CHAN_W-1:0]  chn_q;
	tepq_pkg::entry_t             cur;
	tepq_pkg::entry_t             nxt;
	logic                         match;

	assign cur = '{vld: vld_q, tim: tim_q, chn: chn_q};
	assign ent = cur;

	// empty slots sort after everything; equal times stay in front of the key
	assign gt       = !vld_q || (tim_q > ctl.key_time);
	assign match    = vld_q && (chn_q == ctl.key_chan);
	assign seen_out = seen_in || match;

	// next slot contents
	always_comb begin
		nxt = cur;
		case (ctl.op)
			tepq_pkg::CELL_INSERT: begin
				if (gt) begin
					if (left_gt) begin
						nxt = left_ent;
					end else begin
						nxt = '{vld: 1'b1, tim: ctl.key_time, chn: ctl.key_chan};
					end
				end
			end
			tepq_pkg::CELL_SHIFT: begin
				nxt = right_ent;
			end
			tepq_pkg::CELL_REMOVE: begin
				if (seen_out) begin
					nxt = right_ent;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt.vld;
		end
	end

	// event payload
	always_ff @(posedge clk) begin
		tim_q <= nxt.tim;
		chn_q <= nxt.chn;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/timed_event_priority_queue.sv -----
// ----------------------------------------------------------------------------
// timed_event_priority_queue: sorted queue of timed events
// A row of CAPACITY cells kept in ascending time order with a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (action, event_time, channel) is taken at a rising edge
//   with start high and busy low. Each command gives one response word on
//   rsp, marked by a one-cycle done strobe; the receiver cannot stall it.
//   Push, pop and peek: response in the cycle after the command, and a new
//   command may follow in the next cycle (one command per cycle while idle).
//   Replace: the command cycle removes the earliest event of the channel from
//   the chain, the reinsertion state reinserts it with the new time; busy is
//   high in that state and the response is registered after the reinsertion.
//   A replace that finds no event answers with a not-found status and skips the reinsertion.
//   The cell row sets the timing: every cell compares its own time with the
//   broadcast key and moves one slot per cycle while an operation is broadcast.
//   Ties: a new or replaced event goes behind stored events of equal time.
//   Reset clears all valid flags; the queue comes out of reset empty and idle.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_event_priority_queue #(
	parameter int CAPACITY = 64
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire tepq_pkg::cmd_t  cmd,
	output logic                 done,
	output tepq_pkg::rsp_t       rsp
);

	typedef enum logic [1:0] {
		SEQ_IDLE  = 2'b01,
		SEQ_REINS = 2'b10
	} seq_state_t;

	seq_state_t                   state_q;
	seq_state_t                   state_d;
	logic [tepq_pkg::TIME_W-1:0]  key_time_q;
	logic [tepq_pkg::CHAN_W-1:0]  key_chan_q;
	logic                         done_q;
	tepq_pkg::rsp_t               rsp_q;
	tepq_pkg::rsp_t               rsp_d;
	logic                         done_d;
	tepq_pkg::cell_ctl_t          ctl;
	logic                         accept;
	logic                         full;
	logic                         empty;
	logic                         found;

	tepq_pkg::entry_t             ents  [CAPACITY];
	logic                         gts   [CAPACITY];
	logic                         seens [CAPACITY];

	assign busy   = (state_q == SEQ_REINS);
	assign accept = start && !busy;
	assign full   = ents[CAPACITY-1].vld;
	assign empty  = !ents[0].vld;
	assign found  = seens[CAPACITY-1];

	// cell row
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		tepq_pkg::entry_t left_ent;
		tepq_pkg::entry_t right_ent;
		logic             left_gt;
		logic             seen_in;

		if (i == 0) begin : g_head
			assign left_ent = '0;
			assign left_gt  = 1'b0;
			assign seen_in  = 1'b0;
		end else begin : g_body
			assign left_ent = ents[i-1];
			assign left_gt  = gts[i-1];
			assign seen_in  = seens[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_ent = '0;
		end else begin : g_mid
			assign right_ent = ents[i+1];
		end

		tepq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_ent  (left_ent),
			.left_gt   (left_gt),
			.right_ent (right_ent),
			.seen_in   (seen_in),
			.ent       (ents[i]),
			.gt        (gts[i]),
			.seen_out  (seens[i])
		);
	end

	// sequencer: chain operation, response word, next state
	always_comb begin
		state_d      = state_q;
		done_d       = 1'b0;
		rsp_d        = '{status: tepq_pkg::STAT_OK, out_time: '0, out_channel: '0};
		ctl.op       = tepq_pkg::CELL_HOLD;
		ctl.key_time = cmd.event_time;
		ctl.key_chan = cmd.channel;
		unique case (state_q)
			SEQ_IDLE: begin
				if (accept) begin
					done_d = 1'b1;
					case (cmd.action) inside
						tepq_pkg::ACT_PUSH: begin
							if (full) begin
								rsp_d.status = tepq_pkg::STAT_FULL;
							end else begin
								ctl.op = tepq_pkg::CELL_INSERT;
							end
						end
						tepq_pkg::ACT_POP, tepq_pkg::ACT_PEEK: begin
							if (empty) begin
								rsp_d.status = tepq_pkg::STAT_EMPTY;
							end else begin
								rsp_d.out_time    = ents[0].tim;
								rsp_d.out_channel = ents[0].chn;
								if (cmd.action == tepq_pkg::ACT_POP) begin
									ctl.op = tepq_pkg::CELL_SHIFT;
								end
							end
						end
						default: begin
							// on replace, drop the first match and reinsert next cycle; else not found
							if (found) begin
								ctl.op  = tepq_pkg::CELL_REMOVE;
								done_d  = 1'b0;
								state_d = SEQ_REINS;
							end else begin
								rsp_d.status = tepq_pkg::STAT_NOTFOUND;
							end
						end
					endcase
				end
			end
			SEQ_REINS: begin
				ctl.op       = tepq_pkg::CELL_INSERT;
				ctl.key_time = key_time_q;
				ctl.key_chan = key_chan_q;
				done_d       = 1'b1;
				state_d      = SEQ_IDLE;
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	// key hold for reinsertion, response word
	always_ff @(posedge clk) begin
		if (accept) begin
			key_time_q <= cmd.event_time;
			key_chan_q <= cmd.channel;
		end
		rsp_q <= rsp_d;
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_reins_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_REINS) |=> done_q)
		else $error("reinsertion gave no response");

	a_reins_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_REINS) |-> !done_q)
		else $error("response during removal of a replace");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		ents[1].vld |-> (ents[0].vld && (ents[0].tim <= ents[1].tim)))
		else $error("head of chain out of order");

	a_tail_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		ents[CAPACITY-1].vld |-> ents[CAPACITY-2].vld)
		else $error("gap at tail of chain");
`endif

endmodule

`default_nettype wire
